>>> design/hjd_pkg.sv
`timescale 1ns / 1ps
package hjd_pkg;

	localparam int CFG_W = 10;
	localparam int CFG_IDX_W = 3;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_INSERT_HIGH    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_PRESS_HIGH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HOOK_PRESENT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_JACK_DELAY     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_DELAY  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_HOOK_DELAY     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_MIC_DELAY      = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_STARTUP_DELAY  = 3'd7;

	localparam logic [CFG_W-1:0] JACK_DELAY_RST    = 10'd50;
	localparam logic [CFG_W-1:0] CONFIRM_DELAY_RST = 10'd100;
	localparam logic [CFG_W-1:0] HOOK_DELAY_RST    = 10'd100;
	localparam logic [CFG_W-1:0] MIC_DELAY_RST     = 10'd1;
	localparam logic [CFG_W-1:0] STARTUP_DELAY_RST = 10'd500;

	// jack check phases
	localparam logic [1:0] PH_IDLE    = 2'd0;
	localparam logic [1:0] PH_FIRST   = 2'd1;
	localparam logic [1:0] PH_CONFIRM = 2'd2;

	// jack_state codes
	localparam logic [1:0] JS_NONE     = 2'd0;
	localparam logic [1:0] JS_HEADSET  = 2'd1;
	localparam logic [1:0] JS_HEADPHONE = 2'd2;

	localparam logic EV_HEADPHONE = 1'b0;
	localparam logic EV_HEADSET   = 1'b1;

	typedef struct packed {
		logic             insert_high;
		logic             key_press_high;
		logic             hook_present;
		logic [CFG_W-1:0] jack_delay;
		logic [CFG_W-1:0] confirm_delay;
		logic [CFG_W-1:0] hook_delay;
		logic [CFG_W-1:0] mic_delay;
	} cfg_t;

	typedef struct packed {
		logic jack_pin;
		logic hook_pin;
	} in_t;

	typedef struct packed {
		logic [1:0] jack_state;
		logic       key_status;
		logic       jack_event_valid;
		logic       jack_event_kind;
		logic       jack_event_value;
		logic       key_event_valid;
		logic       key_event_value;
	} out_t;

endpackage

>>> design/hjd_cfg.sv
`timescale 1ns / 1ps
module hjd_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [hjd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [hjd_pkg::CFG_W-1:0]     cfg_data,
	output hjd_pkg::cfg_t                  cfg
);
	import hjd_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.insert_high    <= 1'b1;
			cfg_q.key_press_high <= 1'b1;
			cfg_q.hook_present   <= 1'b1;
			cfg_q.jack_delay     <= JACK_DELAY_RST;
			cfg_q.confirm_delay  <= CONFIRM_DELAY_RST;
			cfg_q.hook_delay     <= HOOK_DELAY_RST;
			cfg_q.mic_delay      <= MIC_DELAY_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_INSERT_HIGH:    cfg_q.insert_high    <= cfg_data[0];
				CFG_KEY_PRESS_HIGH: cfg_q.key_press_high <= cfg_data[0];
				CFG_HOOK_PRESENT:   cfg_q.hook_present   <= cfg_data[0];
				CFG_JACK_DELAY:     cfg_q.jack_delay     <= cfg_data;
				CFG_CONFIRM_DELAY:  cfg_q.confirm_delay  <= cfg_data;
				CFG_HOOK_DELAY:     cfg_q.hook_delay     <= cfg_data;
				CFG_MIC_DELAY:      cfg_q.mic_delay      <= cfg_data;
				// startup delay only shapes the check armed at reset
				CFG_STARTUP_DELAY: begin
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> design/hjd_in_stage.sv
`timescale 1ns / 1ps
module hjd_in_stage (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	input  hjd_pkg::in_t in_data,
	input  logic         ready,
	output logic         valid_s1,
	output hjd_pkg::in_t data_s1
);
	import hjd_pkg::*;

	logic valid_s1_r;
	in_t  data_s1_r;

	// hold the beat while the result stage cannot take it
	assign in_stall = valid_s1_r && !ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_r <= 1'b0;
		end else if (!in_stall) begin
			valid_s1_r <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			data_s1_r <= in_data;
		end
	end

	assign valid_s1 = valid_s1_r;
	assign data_s1  = data_s1_r;

endmodule

>>> design/hjd_core.sv
`timescale 1ns / 1ps
module hjd_core #(
	parameter int DELAY_BITS = 10
) (
	input  logic          clk,
	input  logic          arst_n,
	input  hjd_pkg::cfg_t cfg,
	input  logic          valid_s1,
	input  hjd_pkg::in_t  data_s1,
	output logic          ready,
	output logic          out_valid,
	input  logic          out_stall,
	output hjd_pkg::out_t out_data
);
	import hjd_pkg::*;

	localparam logic [DELAY_BITS-1:0] ONE = DELAY_BITS'(1);

	logic                  inserted_q, hook_status_q, hook_detect_on_q, mic_fitted_q;
	logic [1:0]            jack_code_q, jack_phase_q;
	logic [DELAY_BITS-1:0] jack_count_q, mic_count_q, hook_count_q;
	logic                  first_sample_q, mic_pending_q, hook_pending_q;
	logic                  last_jack_q, last_hook_q;

	logic                  ins_n, hs_n, hdo_n, mf_n, fs_n, mp_n, hpd_n;
	logic [1:0]            code_n, ph_n;
	logic [DELAY_BITS-1:0] jc_n, mc_n, hc_n;
	out_t                  res;
	logic                  jack_in, hook_dn;

	logic out_valid_q;
	out_t out_data_q;
	logic adv;

	assign ready = !out_valid_q || !out_stall;
	assign adv   = valid_s1 && ready;

	assign jack_in = cfg.insert_high ? data_s1.jack_pin : !data_s1.jack_pin;
	assign hook_dn = cfg.key_press_high ? data_s1.hook_pin : !data_s1.hook_pin;

	always_comb begin
		ins_n  = inserted_q;
		hs_n   = hook_status_q;
		hdo_n  = hook_detect_on_q;
		mf_n   = mic_fitted_q;
		code_n = jack_code_q;
		ph_n   = jack_phase_q;
		jc_n   = jack_count_q;
		fs_n   = first_sample_q;
		mp_n   = mic_pending_q;
		mc_n   = mic_count_q;
		hpd_n  = hook_pending_q;
		hc_n   = hook_count_q;
		res    = '0;

		// jack check
		unique case (jack_phase_q)
			PH_FIRST: begin
				if (jack_count_q <= ONE) begin
					fs_n = data_s1.jack_pin;
					ph_n = PH_CONFIRM;
					jc_n = DELAY_BITS'(cfg.confirm_delay);
				end else begin
					jc_n = jack_count_q - ONE;
				end
			end
			PH_CONFIRM: begin
				if (jack_count_q <= ONE) begin
					jc_n = '0;
					ph_n = PH_IDLE;
					if (first_sample_q == data_s1.jack_pin && jack_in != inserted_q) begin
						ins_n = jack_in;
						if (jack_in) begin
							code_n = JS_HEADPHONE;
							if (cfg.hook_present) begin
								if (!mic_pending_q) begin
									mp_n = 1'b1;
									mc_n = DELAY_BITS'(cfg.mic_delay);
								end
							end else begin
								res.jack_event_valid = 1'b1;
								res.jack_event_kind  = EV_HEADPHONE;
								res.jack_event_value = 1'b1;
							end
						end else begin
							hs_n   = 1'b0;
							hdo_n  = 1'b0;
							code_n = JS_NONE;
							res.jack_event_valid = 1'b1;
							res.jack_event_kind  = EV_HEADPHONE;
							res.jack_event_value = 1'b0;
						end
					end
				end else begin
					jc_n = jack_count_q - ONE;
				end
			end
			default: ph_n = PH_IDLE;
		endcase

		// mic timer; may fire on the tick that armed it
		if (mp_n) begin
			if (mc_n <= ONE) begin
				mc_n = '0;
				mp_n = 1'b0;
				if (ins_n && cfg.hook_present) begin
					mf_n = !hook_dn;
					if (!hook_dn) begin
						hdo_n = 1'b1;
						hs_n  = 1'b0;
					end
					code_n = hook_dn ? JS_HEADPHONE : JS_HEADSET;
					res.jack_event_valid = 1'b1;
					res.jack_event_kind  = EV_HEADSET;
					res.jack_event_value = !hook_dn;
				end
			end else begin
				mc_n = mc_n - ONE;
			end
		end

		// hook check
		if (hook_pending_q) begin
			if (hook_count_q <= ONE) begin
				hc_n  = '0;
				hpd_n = 1'b0;
				if (ins_n && hook_dn != hs_n) begin
					hs_n = hook_dn;
					res.key_event_valid = 1'b1;
					res.key_event_value = hook_dn;
				end
			end else begin
				hc_n = hook_count_q - ONE;
			end
		end

		// edge detection arms new checks; pending ones run on
		if (data_s1.jack_pin != last_jack_q && jack_in != ins_n && ph_n == PH_IDLE) begin
			ph_n = PH_FIRST;
			jc_n = DELAY_BITS'(cfg.jack_delay);
		end
		if (hdo_n && data_s1.hook_pin != last_hook_q && hook_dn != hs_n && !hpd_n) begin
			hpd_n = 1'b1;
			hc_n  = DELAY_BITS'(cfg.hook_delay);
		end

		res.jack_state = code_n;
		res.key_status = hs_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inserted_q       <= 1'b0;
			hook_status_q    <= 1'b0;
			hook_detect_on_q <= 1'b0;
			mic_fitted_q     <= 1'b0;
			jack_code_q      <= JS_NONE;
			jack_phase_q     <= PH_FIRST;
			jack_count_q     <= DELAY_BITS'(STARTUP_DELAY_RST);
			first_sample_q   <= 1'b0;
			mic_pending_q    <= 1'b0;
			mic_count_q      <= '0;
			hook_pending_q   <= 1'b0;
			hook_count_q     <= '0;
			last_jack_q      <= 1'b0;
			last_hook_q      <= 1'b0;
		end else if (adv) begin
			inserted_q       <= ins_n;
			hook_status_q    <= hs_n;
			hook_detect_on_q <= hdo_n;
			mic_fitted_q     <= mf_n;
			jack_code_q      <= code_n;
			jack_phase_q     <= ph_n;
			jack_count_q     <= jc_n;
			first_sample_q   <= fs_n;
			mic_pending_q    <= mp_n;
			mic_count_q      <= mc_n;
			hook_pending_q   <= hpd_n;
			hook_count_q     <= hc_n;
			last_jack_q      <= data_s1.jack_pin;
			last_hook_q      <= data_s1.hook_pin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_jack_unused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_data_q.jack_event_valid |->
			!out_data_q.jack_event_kind && !out_data_q.jack_event_value)
		else $error("jack report fields set without a report");

	a_key_unused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_data_q.key_event_valid |-> !out_data_q.key_event_value)
		else $error("key value set without a report");

	a_state_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_data_q.jack_state != 2'd3)
		else $error("illegal jack state code");

	a_hook_needs_plug: assert property (@(posedge clk) disable iff (!arst_n)
		hook_detect_on_q || hook_status_q |-> inserted_q)
		else $error("hook active while unplugged");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q && $stable(out_data_q))
		else $error("stalled result changed");

endmodule

>>> design/headset_jack_detect_unit.sv
`timescale 1ns / 1ps
// Headset jack and hook-key detector. Each input beat is one millisecond tick carrying
// the jack and hook pin levels; each tick yields exactly one result beat with the plug
// state, hook status and any jack or key report made on that tick. One tick is taken
// per clock while the output is not stalled; an accepted tick passes through the input
// register, then the result register that holds the detector state update, where its
// result is presented. Delays are tick counts in the configuration registers; write them
// only while no tick is in flight. The startup check armed at reset always counts the
// reset value of the startup delay.
module headset_jack_detect_unit #(
	parameter int DELAY_BITS = 10
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [hjd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [hjd_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  hjd_pkg::in_t                   in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output hjd_pkg::out_t                  out_data
);
	import hjd_pkg::*;

	cfg_t cfg;
	logic ready;
	logic valid_s1;
	in_t  data_s1;

	hjd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	hjd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.ready    (ready),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1)
	);

	hjd_core #(
		.DELAY_BITS (DELAY_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.valid_s1  (valid_s1),
		.data_s1   (data_s1),
		.ready     (ready),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
